// File: rtl/core/rrps_pkg.sv
// Shared types and constants for the rounded rectangle pixel shader.
package rrps_pkg;

  localparam int FRAC_BITS      = 8;
  localparam int COORD_W        = 18;
  localparam int DIST_W         = 11;
  localparam int SQR_W          = 2 * DIST_W;
  localparam int SQ_W           = SQR_W + 1;
  localparam int ROOT_W         = 20;
  localparam int RAD_W          = 2 * ROOT_W;
  localparam int REM_W          = ROOT_W + 2;
  localparam int CH_W           = 8;
  localparam int RGB_W          = 3 * CH_W;
  localparam int MAX_BUFFER_DIM = 4096;

  typedef enum logic [2:0] {
    REG_BUFFER_WIDTH  = 3'd0,
    REG_BUFFER_HEIGHT = 3'd1,
    REG_RECT_LEFT     = 3'd2,
    REG_RECT_TOP      = 3'd3,
    REG_RECT_WIDTH    = 3'd4,
    REG_RECT_HEIGHT   = 3'd5,
    REG_CORNER_RADIUS = 3'd6,
    REG_FILL_COLOR    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [12:0] buffer_width;
    logic [12:0] buffer_height;
    logic [14:0] rect_left;
    logic [14:0] rect_top;
    logic [13:0] rect_width;
    logic [13:0] rect_height;
    logic [10:0] corner_radius;
    logic [31:0] fill_color;
  } cfg_t;

  typedef struct packed {
    logic             in_rect;
    logic             full;
    logic [RGB_W-1:0] bg;
  } side_t;

endpackage

// File: rtl/core/rrps_geom.sv
// Clipping, corner distances, squares and their sum in four stages.
module rrps_geom import rrps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic [11:0]      pixel_col,
  input  logic [11:0]      pixel_row,
  input  logic [RGB_W-1:0] bg,
  output logic             out_valid,
  output logic [SQ_W-1:0]  sq,
  output side_t            out_side
);

  localparam logic signed [COORD_W-1:0] DIM_MAX = COORD_W'(MAX_BUFFER_DIM);

  logic signed [COORD_W-1:0] left_s, top_s, right_raw, bottom_raw, bw_s, bh_s, r_s;
  logic signed [COORD_W-1:0] left_c, top_c, right_c, bottom_c;

  always_comb begin
    left_s     = {{(COORD_W-15){cfg.rect_left[14]}}, cfg.rect_left};
    top_s      = {{(COORD_W-15){cfg.rect_top[14]}}, cfg.rect_top};
    right_raw  = left_s + {{(COORD_W-14){1'b0}}, cfg.rect_width};
    bottom_raw = top_s + {{(COORD_W-14){1'b0}}, cfg.rect_height};
    bw_s       = {{(COORD_W-13){1'b0}}, cfg.buffer_width};
    bh_s       = {{(COORD_W-13){1'b0}}, cfg.buffer_height};
    if (bw_s > DIM_MAX) bw_s = DIM_MAX;
    if (bh_s > DIM_MAX) bh_s = DIM_MAX;
    r_s        = {{(COORD_W-11){1'b0}}, cfg.corner_radius};
    left_c     = (left_s < 0) ? '0 : left_s;
    top_c      = (top_s < 0) ? '0 : top_s;
    right_c    = (right_raw > bw_s) ? bw_s : right_raw;
    bottom_c   = (bottom_raw > bh_s) ? bh_s : bottom_raw;
  end

  // Stage 1: clipped bounds and corner circle centers.
  logic                      v1;
  logic signed [COORD_W-1:0] l1, t1, r1, b1, lr1, rr1, tr1, br1;
  logic [11:0]               col1, row1;
  logic [RGB_W-1:0]          bg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      l1   <= left_c;
      t1   <= top_c;
      r1   <= right_c;
      b1   <= bottom_c;
      lr1  <= left_c + r_s;
      rr1  <= right_c - r_s;
      tr1  <= top_c + r_s;
      br1  <= bottom_c - r_s;
      col1 <= pixel_col;
      row1 <= pixel_row;
      bg1  <= bg;
    end
  end

  // Stage 2: inside test and the distances to the nearest corner center.
  logic signed [COORD_W-1:0] px, py, hd, vd;
  logic                      inside2_next;

  always_comb begin
    px = {{(COORD_W-12){1'b0}}, col1};
    py = {{(COORD_W-12){1'b0}}, row1};
    inside2_next = (l1 < r1) && (t1 < b1) && (px >= l1) && (px < r1) &&
                   (py >= t1) && (py < b1);
    if (px < lr1)      hd = lr1 - px;
    else if (px > rr1) hd = px - rr1;
    else               hd = '0;
    if (py < tr1)      vd = tr1 - py;
    else if (py > br1) vd = py - br1;
    else               vd = '0;
  end

  logic              v2;
  logic [DIST_W-1:0] h2, vv2;
  side_t             s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      h2         <= hd[DIST_W-1:0];
      vv2        <= vd[DIST_W-1:0];
      s2.in_rect <= inside2_next;
      s2.full    <= (hd == 0) && (vd == 0);
      s2.bg      <= bg1;
    end
  end

  // Stage 3: squares.
  logic             v3;
  logic [SQR_W-1:0] hh3, vq3;
  side_t            s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      hh3 <= h2 * h2;
      vq3 <= vv2 * vv2;
      s3  <= s2;
    end
  end

  // Stage 4: sum of squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
    if (en) begin
      sq       <= {1'b0, hh3} + {1'b0, vq3};
      out_side <= s3;
    end
  end

endmodule

// File: rtl/core/rrps_sqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
module rrps_sqrt import rrps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   sq,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output side_t             out_side
);

  logic [RAD_W-1:0]  n_q    [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic              vq     [ROOT_W];
  side_t             side_q [ROOT_W];

  // The radicand carries the fraction bits of the distance.
  logic [RAD_W-1:0] rad_in;
  assign rad_in = {{(RAD_W-SQ_W-2*FRAC_BITS){1'b0}}, sq, {(2*FRAC_BITS){1'b0}}};

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int I = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  n_in;
    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;
    logic              v_in;
    side_t             side_in;

    if (k == 0) begin : g_first
      assign n_in    = rad_in;
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign n_in    = n_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = vq[k-1];
      assign side_in = side_q[k-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], n_in[2*I+1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k] <= 1'b0;
      end else if (en) begin
        vq[k] <= v_in;
      end
      if (en) begin
        n_q[k]    <= n_in;
        side_q[k] <= side_in;
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vq[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];
  assign out_side  = side_q[ROOT_W-1];

endmodule

// File: rtl/core/rrps_blend.sv
// Coverage from distance, then the color blend, in two stages.
module rrps_blend import rrps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] distance,
  input  side_t             in_side,
  output logic              out_valid,
  output logic              write_enable,
  output logic [31:0]       pixel_value
);

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic [CH_W-1:0] mix(input logic [CH_W-1:0] fg,
                                          input logic [CH_W-1:0] bk,
                                          input logic [FRAC_BITS-1:0] c);
    logic [FRAC_BITS:0]          inv;
    logic [CH_W+FRAC_BITS+1:0]   fg_w, bk_w, c_w, inv_w, acc;
    inv   = ONE - {1'b0, c};
    fg_w  = (CH_W+FRAC_BITS+2)'(fg);
    bk_w  = (CH_W+FRAC_BITS+2)'(bk);
    c_w   = (CH_W+FRAC_BITS+2)'(c);
    inv_w = (CH_W+FRAC_BITS+2)'(inv);
    acc   = fg_w * c_w + bk_w * inv_w;
    return acc[FRAC_BITS +: CH_W];
  endfunction

  // Radius in fixed point plus one half.
  logic [ROOT_W-1:0] pos, cov;
  logic              hit;

  always_comb begin
    pos = ROOT_W'({cfg.corner_radius, 1'b1, {(FRAC_BITS-1){1'b0}}});
    hit = distance < pos;
    cov = pos - distance;
  end

  logic                 va, we_a, solid_a;
  logic [FRAC_BITS-1:0] c_a;
  logic [RGB_W-1:0]     bg_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      we_a    <= in_side.in_rect && (in_side.full || hit);
      solid_a <= in_side.full || (cov[ROOT_W-1:FRAC_BITS] != 0);
      c_a     <= cov[FRAC_BITS-1:0];
      bg_a    <= in_side.bg;
    end
  end

  logic [31:0] value_next;

  always_comb begin
    if (!we_a) begin
      value_next = '0;
    end else if (solid_a) begin
      value_next = cfg.fill_color;
    end else begin
      value_next = {8'h00,
                    mix(cfg.fill_color[23:16], bg_a[23:16], c_a),
                    mix(cfg.fill_color[15:8], bg_a[15:8], c_a),
                    mix(cfg.fill_color[7:0], bg_a[7:0], c_a)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= va;
    end
    if (en) begin
      write_enable <= we_a;
      pixel_value  <= value_next;
    end
  end

endmodule

// File: rtl/core/rounded_rect_pixel_shader.sv
// Top level of the antialiased rounded rectangle pixel shader.
//
// The block shades one pixel per word. A slave stream word carries the pixel
// column, row and the background word already in the buffer there; the master
// stream returns one word per pixel with the new pixel word in tdata and the
// write enable flag in tuser. A disabled write always carries a zero word.
// The rectangle, clip bounds, corner radius and fill color are set through the
// configuration write channel, which is always ready; write it only while no
// pixel is in flight.
//
// Throughput is one pixel per clock while the receiver does not stall. A pixel
// passes 26 register stages: four of clipping and distance math, twenty of
// the square root (one root bit per stage) and two of coverage and
// blending. The last stage is the output register.
//
// Reset clears all configuration registers to zero and empties the pipeline.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// tready drops on the input side; nothing is dropped or repeated.
module rounded_rect_pixel_shader import rrps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Pixel input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: pixel_col[11:0], pixel_row[23:12],
  // background_pixel[55:24].
  input  logic [55:0] s_axis_tdata,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: pixel_value[31:0].
  output logic [31:0] m_axis_tdata,
  // Fields from bit 0: write_enable[0].
  output logic [0:0]  m_axis_tuser
);

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BUFFER_WIDTH:  cfg.buffer_width  <= cfg_data[12:0];
        REG_BUFFER_HEIGHT: cfg.buffer_height <= cfg_data[12:0];
        REG_RECT_LEFT:     cfg.rect_left     <= cfg_data[14:0];
        REG_RECT_TOP:      cfg.rect_top      <= cfg_data[14:0];
        REG_RECT_WIDTH:    cfg.rect_width    <= cfg_data[13:0];
        REG_RECT_HEIGHT:   cfg.rect_height   <= cfg_data[13:0];
        REG_CORNER_RADIUS: cfg.corner_radius <= cfg_data[10:0];
        REG_FILL_COLOR:    cfg.fill_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves as one whenever the output register can take a word.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic            g_valid;
  logic [SQ_W-1:0] g_sq;
  side_t           g_side;

  rrps_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .pixel_col (s_axis_tdata[11:0]),
    .pixel_row (s_axis_tdata[23:12]),
    .bg        (s_axis_tdata[24 +: RGB_W]),
    .out_valid (g_valid),
    .sq        (g_sq),
    .out_side  (g_side)
  );

  logic              r_valid;
  logic [ROOT_W-1:0] r_root;
  side_t             r_side;

  rrps_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .sq        (g_sq),
    .in_side   (g_side),
    .out_valid (r_valid),
    .root      (r_root),
    .out_side  (r_side)
  );

  rrps_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .in_valid     (r_valid),
    .distance     (r_root),
    .in_side      (r_side),
    .out_valid    (m_axis_tvalid),
    .write_enable (m_axis_tuser[0]),
    .pixel_value  (m_axis_tdata)
  );

  // A pixel that is not written always carries a zero word.
  a_zero_when_off: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'h0)
    else $error("unwritten pixel carries a nonzero word");

  // A written word is either the fill color or a blend with a clear top byte.
  a_top_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata == cfg.fill_color) || (m_axis_tdata[31:24] == 8'h00))
    else $error("blended pixel has a nonzero top byte");

  // Input is refused only while a result waits on the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  // A stalled output stays valid and keeps its write enable flag for the next cycle.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

// File: tb/rounded_rect_pixel_shader_checker.sv
// Shading predictor and result checker for the rounded rectangle pixel shader.
`timescale 1ns / 100ps

module rounded_rect_pixel_shader_checker import rrps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic        write_enable;
    logic [31:0] pixel_value;
  } shaded_t;

  cfg_t    shade_cfg;
  shaded_t shaded_q[$];

  assign pending_count = shaded_q.size();

  function automatic logic [63:0] root_of(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] t;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (t * t <= n) root = t;
    end
    return root;
  endfunction

  function automatic logic [7:0] mix_channel(logic [7:0] fg, logic [7:0] bg, int unsigned c);
    int unsigned sum;
    sum = fg * c + bg * (256 - c);
    return sum[15:8];
  endfunction

  function automatic shaded_t shade_pixel(cfg_t c, logic [11:0] col, logic [11:0] row,
                                          logic [31:0] bg);
    shaded_t res;
    int bw, bh, rad, left, top, right, bottom, px, py;
    longint h, v, d, pos, cov;
    res = '0;
    bw = (c.buffer_width > 4096) ? 4096 : c.buffer_width;
    bh = (c.buffer_height > 4096) ? 4096 : c.buffer_height;
    rad = c.corner_radius;
    left = $signed(c.rect_left);
    top = $signed(c.rect_top);
    right = left + int'(c.rect_width);
    bottom = top + int'(c.rect_height);
    px = col;
    py = row;
    h = 0;
    v = 0;
    if (left < 0) left = 0;
    if (top < 0) top = 0;
    if (right > bw) right = bw;
    if (bottom > bh) bottom = bh;
    if (left >= right || top >= bottom) return res;
    if (px < left || px >= right || py < top || py >= bottom) return res;
    if (px < left + rad) h = left + rad - px;
    else if (px > right - rad) h = px - (right - rad);
    if (py < top + rad) v = top + rad - py;
    else if (py > bottom - rad) v = py - (bottom - rad);
    if (h == 0 && v == 0) begin
      res.write_enable = 1'b1;
      res.pixel_value = c.fill_color;
      return res;
    end
    d = root_of((h * h + v * v) << 16);
    pos = (longint'(rad) << 8) + 128;
    if (d >= pos) return res;
    cov = pos - d;
    res.write_enable = 1'b1;
    if (cov >= 256) begin
      res.pixel_value = c.fill_color;
    end else begin
      res.pixel_value = {8'h00,
                         mix_channel(c.fill_color[23:16], bg[23:16], cov),
                         mix_channel(c.fill_color[15:8], bg[15:8], cov),
                         mix_channel(c.fill_color[7:0], bg[7:0], cov)};
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    shaded_t want;
    if (rst) begin
      shade_cfg <= '0;
      shaded_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (shaded_q.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 32'h0);
        end else begin
          want = shaded_q.pop_front();
          if (m_axis_tuser[0] !== want.write_enable)
            report_mismatch("write_enable", m_axis_tuser[0], want.write_enable);
          if (m_axis_tdata !== want.pixel_value)
            report_mismatch("pixel_value", m_axis_tdata, want.pixel_value);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        shaded_q.push_back(shade_pixel(shade_cfg, s_axis_tdata[11:0], s_axis_tdata[23:12],
                                       s_axis_tdata[55:24]));
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_BUFFER_WIDTH:  shade_cfg.buffer_width <= cfg_data[12:0];
          REG_BUFFER_HEIGHT: shade_cfg.buffer_height <= cfg_data[12:0];
          REG_RECT_LEFT:     shade_cfg.rect_left <= cfg_data[14:0];
          REG_RECT_TOP:      shade_cfg.rect_top <= cfg_data[14:0];
          REG_RECT_WIDTH:    shade_cfg.rect_width <= cfg_data[13:0];
          REG_RECT_HEIGHT:   shade_cfg.rect_height <= cfg_data[13:0];
          REG_CORNER_RADIUS: shade_cfg.corner_radius <= cfg_data[10:0];
          REG_FILL_COLOR:    shade_cfg.fill_color <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/rounded_rect_pixel_shader_test.sv
// Stimulus and verdict for the rounded rectangle pixel shader regression.
`timescale 1ns / 100ps

module rounded_rect_pixel_shader_test;
  import rrps_pkg::*;

  // Pipeline depth: the register stages between the input and the output.
  localparam int LATENCY = 26;
  localparam int DRAIN_CYCLES = 2 * LATENCY;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // Fields from bit 0: pixel_col[11:0], pixel_row[23:12], background_pixel[55:24].
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // Fields from bit 0: pixel_value[31:0].
  logic [31:0] m_axis_tdata;
  // Fields from bit 0: write_enable[0].
  logic [0:0]  m_axis_tuser;

  int fail_count;
  int pending_count;
  int cycle_count;
  // Set for the closing part of the run, where neither side idles.
  logic steady_flow;
  // Asks the receiver process for one long hold-off.
  logic hold_request;

  rounded_rect_pixel_shader u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  rounded_rect_pixel_shader_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("rounded_rect_pixel_shader regression: fail");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, and one long hold-off on request so the
  // pipeline fills and the input side backs up.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (3 * LATENCY) @(negedge clk);
        hold_request = 1'b0;
      end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // Writes one register while the block is idle; the channel is always ready.
  // The caller drops cfg_valid after its last write.
  task automatic write_register(reg_index_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_shape(int bw, int bh, int left, int top, int w, int h, int rad,
                            logic [31:0] color);
    write_register(REG_BUFFER_WIDTH, bw);
    write_register(REG_BUFFER_HEIGHT, bh);
    write_register(REG_RECT_LEFT, left);
    write_register(REG_RECT_TOP, top);
    write_register(REG_RECT_WIDTH, w);
    write_register(REG_RECT_HEIGHT, h);
    write_register(REG_CORNER_RADIUS, rad);
    write_register(REG_FILL_COLOR, color);
    cfg_valid <= 1'b0;
  endtask

  // Offers one pixel word, with an optional idle burst ahead of it, and
  // returns at the falling edge after it was taken.
  task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [31:0] bg);
    if (!steady_flow && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {bg, row, col};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every expected word is back, then lets the pipe settle.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Pixels mostly near the clipped rectangle so corners and edges are hit,
  // with a share spread over the whole coordinate range.
  task automatic random_pixels(int count, int left, int top, int w, int h);
    int col;
    int row;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        col = $urandom_range(0, 4095);
        row = $urandom_range(0, 4095);
      end else begin
        col = left + $urandom_range(0, w + 8) - 4;
        row = top + $urandom_range(0, h + 8) - 4;
        if (col < 0) col = 0;
        if (row < 0) row = 0;
        if (col > 4095) col = 4095;
        if (row > 4095) row = 4095;
      end
      send_pixel(12'(col), 12'(row), $urandom);
    end
  endtask

  initial begin
    int left, top, w, h, rad, bw, bh;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    steady_flow = 1'b0;
    hold_request = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset values: the rectangle is empty, so nothing is ever written.
    send_pixel(0, 0, 32'hFFFF_FFFF);
    send_pixel(12'hFFF, 12'hFFF, 32'h0);
    drain_pipeline();

    // Square corners on a small rectangle: edges and the inner fill word.
    load_shape(64, 64, 10, 10, 20, 20, 0, 32'hAB12_3456);
    send_pixel(10, 10, 32'h0);
    send_pixel(29, 29, 32'h0);
    send_pixel(30, 10, 32'h0);
    send_pixel(9, 15, 32'h0);
    drain_pipeline();

    // Round corners: corner arc, the partial blend, zero coverage at the tip.
    load_shape(64, 64, 4, 4, 40, 30, 8, 32'hFF80_40C0);
    send_pixel(4, 4, 32'h00FF_FFFF);
    send_pixel(6, 6, 32'h1234_5678);
    send_pixel(7, 5, 32'hFFFF_FFFF);
    send_pixel(5, 8, 32'h00A5_5A00);
    send_pixel(43, 33, 32'h0055_AA55);
    send_pixel(20, 20, 32'hFFFF_FFFF);
    drain_pipeline();

    // Extremes: oversized buffer, negative origin, widest rectangle and
    // the largest radius, plus a clipped-away rectangle.
    load_shape(8191, 8191, -16384, -16384, 16383, 16383, 2047, 32'hFFFF_FFFF);
    send_pixel(0, 0, 32'h0);
    send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    send_pixel(2047, 100, 32'h0);
    drain_pipeline();
    load_shape(4096, 4096, 16383, 16383, 16383, 16383, 1, 32'h0);
    send_pixel(4095, 4095, 32'hFFFF_FFFF);
    drain_pipeline();

    // Random shapes, with the long receiver hold-off in the first one.
    for (int phase = 0; phase < 10; phase++) begin
      bw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(16, 300);
      bh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(16, 300);
      left = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 32767)) - 16384
                                       : int'($urandom_range(0, 200)) - 40;
      top = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 32767)) - 16384
                                      : int'($urandom_range(0, 200)) - 40;
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 200);
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 200);
      rad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 60);
      load_shape(bw, bh, left, top, w, h, rad, $urandom);
      if (phase == 0) hold_request = 1'b1;
      if (phase == 9) steady_flow = 1'b1;
      if (left < 0) begin
        w = w + left;
        left = 0;
      end
      if (top < 0) begin
        h = h + top;
        top = 0;
      end
      if (w < 0) w = 0;
      if (h < 0) h = 0;
      if (w > 300) w = 300;
      if (h > 300) h = 300;
      random_pixels(108, left, top, w, h);
      drain_pipeline();
    end

    if (fail_count == 0) begin
      $display("rounded_rect_pixel_shader regression: pass");
    end else begin
      $display("rounded_rect_pixel_shader regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/rrps_pkg.sv
rtl/core/rrps_geom.sv
rtl/core/rrps_sqrt.sv
rtl/core/rrps_blend.sv
rtl/core/rounded_rect_pixel_shader.sv
tb/rounded_rect_pixel_shader_checker.sv
tb/rounded_rect_pixel_shader_test.sv
